### rtl/aux_rom_decrypt_overlay_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the aux ROM decrypt overlay
// Concurrent checks sampled on the rising clock, muted while reset is low.
// ----------------------------------------------------------------------------
`ifndef AUX_ROM_DECRYPT_OVERLAY_ASSERT_SVH
`define AUX_ROM_DECRYPT_OVERLAY_ASSERT_SVH
`ifndef SYNTH
// property must hold at every edge out of reset
`define ARDO_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// condition must never be true out of reset
`define ARDO_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define ARDO_ASSERT(lbl, clk, rstn, prop, msg)
`define ARDO_ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

### rtl/ardo_pkg.sv
// ----------------------------------------------------------------------------
// ardo_pkg
// Shared types, address map codes, bit permutations and patch window table.
// ----------------------------------------------------------------------------
package ardo_pkg;

  localparam int unsigned RawDepthDef = 32768;
  localparam int unsigned IdxW        = 15;
  localparam int unsigned QueueDepth  = 2;
  localparam int unsigned QPtrW       = 1;
  localparam int unsigned QCntW       = 2;
  localparam int unsigned NumPatch    = 40;

  localparam logic CmdLoad     = 1'b0;
  localparam logic CmdRead     = 1'b1;
  localparam logic BankPlain   = 1'b0;
  localparam logic BankDecrypt = 1'b1;

  // one operation handed from the front to the back
  typedef struct packed {
    logic            is_load;
    logic            decrypt;
    logic            mapped;
    logic [IdxW-1:0] idx;
    logic [7:0]      wdata;
  } op_t;

  localparam int unsigned DataSel[8]  = '{0, 4, 5, 7, 6, 3, 2, 1};
  localparam int unsigned U7Sel[12]   = '{11, 3, 7, 9, 10, 8, 6, 5, 4, 2, 1, 0};
  localparam int unsigned U5Sel[11]   = '{8, 7, 5, 9, 10, 6, 3, 4, 2, 1, 0};
  localparam int unsigned U6Sel[11]   = '{3, 7, 9, 10, 8, 6, 5, 4, 2, 1, 0};

  localparam logic [15:0] PatchDst[NumPatch] = '{
    16'h0410, 16'h08e0, 16'h0a30, 16'h0bd0, 16'h0c20, 16'h0e58, 16'h0ea8, 16'h1000,
    16'h1008, 16'h1288, 16'h1348, 16'h1688, 16'h16b0, 16'h16d8, 16'h16f8, 16'h19a8,
    16'h19b8, 16'h2060, 16'h2108, 16'h21a0, 16'h2298, 16'h23e0, 16'h2418, 16'h2448,
    16'h2470, 16'h2488, 16'h24b0, 16'h24d8, 16'h24f8, 16'h2748, 16'h2780, 16'h27b8,
    16'h2800, 16'h2b20, 16'h2b30, 16'h2bf0, 16'h2cc0, 16'h2cd8, 16'h2cf0, 16'h2d60};

  localparam logic [15:0] PatchSrc[NumPatch] = '{
    16'h8008, 16'h81d8, 16'h8118, 16'h80d8, 16'h8120, 16'h8168, 16'h8198, 16'h8020,
    16'h8010, 16'h8098, 16'h8048, 16'h8088, 16'h8188, 16'h80c8, 16'h81c8, 16'h80a8,
    16'h81a8, 16'h8148, 16'h8018, 16'h81a0, 16'h80a0, 16'h80e8, 16'h8000, 16'h8058,
    16'h8140, 16'h8080, 16'h8180, 16'h80c0, 16'h81c0, 16'h8050, 16'h8090, 16'h8190,
    16'h8028, 16'h8100, 16'h8110, 16'h81d0, 16'h80d0, 16'h80e0, 16'h81e0, 16'h8160};

  // result bit (n-1-k) takes source bit sel[k]
  function automatic logic [7:0] perm_data(logic [7:0] v);
    logic [7:0] r;
    r = '0;
    for (int k = 0; k < 8; k++) r[7-k] = v[DataSel[k]];
    return r;
  endfunction

  function automatic logic [11:0] perm_u7(logic [11:0] v);
    logic [11:0] r;
    r = '0;
    for (int k = 0; k < 12; k++) r[11-k] = v[U7Sel[k]];
    return r;
  endfunction

  function automatic logic [10:0] perm_u5(logic [10:0] v);
    logic [10:0] r;
    r = '0;
    for (int k = 0; k < 11; k++) r[10-k] = v[U5Sel[k]];
    return r;
  endfunction

  function automatic logic [10:0] perm_u6(logic [10:0] v);
    logic [10:0] r;
    r = '0;
    for (int k = 0; k < 11; k++) r[10-k] = v[U6Sel[k]];
    return r;
  endfunction

endpackage

### rtl/ardo_in_if.sv
// ----------------------------------------------------------------------------
// ardo_in_if
// Request channel: loads and reads with valid/ready handshake.
// ----------------------------------------------------------------------------
interface ardo_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic        bank;
  logic [15:0] address;
  logic [7:0]  load_byte;

  modport source (output valid, output cmd, output bank, output address,
                  output load_byte, input ready);
  modport sink   (input valid, input cmd, input bank, input address,
                  input load_byte, output ready);
endinterface

### rtl/ardo_out_if.sv
// ----------------------------------------------------------------------------
// ardo_out_if
// Response channel: one byte and a mapped flag per read.
// ----------------------------------------------------------------------------
interface ardo_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_byte;
  logic       mapped;

  modport source (output valid, output read_byte, output mapped, input ready);
  modport sink   (input valid, input read_byte, input mapped, output ready);
endinterface

### rtl/aux_rom_decrypt_overlay.sv
// ----------------------------------------------------------------------------
// aux_rom_decrypt_overlay
// Program ROM view of an auxiliary board with encrypted overlay images.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries load and read items. A load writes one raw byte into the
//   32K image store and returns nothing; loads outside the base and aux
//   image ranges are dropped. A read names a bank (plain or decrypted) and
//   a CPU address and returns one item on out_o: the byte and a mapped flag
//   (unmapped addresses give zero with mapped low).
//   Path: a read presented to an empty block lands in the queue at the
//   accepting edge; the registered store read then loads the result
//   register, which drives out_o.
//   Throughput: one item per cycle while out_o is not stalling, set by the
//   single store port that serves one load or one read each cycle.
//   Backpressure: when out_o stalls the result register holds; the two-entry
//   queue keeps taking items until it fills, then in_i.ready drops.
//   Reset: control clears at once; store contents are undefined until
//   loaded, so every byte must be loaded before it is read.
// ----------------------------------------------------------------------------
module aux_rom_decrypt_overlay #(
  parameter int unsigned RawDepth = ardo_pkg::RawDepthDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ardo_in_if.sink    in_i,
  ardo_out_if.source out_o
);
  import ardo_pkg::*;

  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_valid;
  op_t  push_op;
  op_t  pop_op;

  ardo_front u_front (
    .in_i     (in_i),
    .q_full_i (q_full),
    .q_push_o (q_push),
    .q_op_o   (push_op)
  );

  ardo_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (q_push),
    .push_op_i (push_op),
    .full_o    (q_full),
    .pop_i     (q_pop),
    .valid_o   (q_valid),
    .pop_op_o  (pop_op)
  );

  ardo_back #(
    .RawDepth (RawDepth)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_op_i    (pop_op),
    .q_pop_o   (q_pop),
    .out_o     (out_o)
  );

endmodule

### rtl/ardo_front.sv
// ----------------------------------------------------------------------------
// ardo_front
// Accepts items, decodes the bank map and patch windows into store indexes.
// ----------------------------------------------------------------------------
module ardo_front (
  ardo_in_if.sink         in_i,
  input  logic            q_full_i,
  output logic            q_push_o,
  output ardo_pkg::op_t   q_op_o
);
  import ardo_pkg::*;

  logic [15:0] addr;
  logic        keep;
  logic        patch_hit;
  logic [10:0] patch_off;
  op_t         op;

  assign addr = in_i.address;

  // later windows win, as in the table order
  always_comb begin
    patch_hit = 1'b0;
    patch_off = '0;
    for (int p = 0; p < NumPatch; p++) begin
      if (addr[15:3] == PatchDst[p][15:3]) begin
        patch_hit = 1'b1;
        patch_off = {PatchSrc[p][10:3], addr[2:0]};
      end
    end
  end

  always_comb begin
    op       = '0;
    keep     = 1'b0;
    op.wdata = in_i.load_byte;
    if (in_i.cmd == CmdLoad) begin
      op.is_load = 1'b1;
      // drop loads outside the two image ranges
      if (addr[15:14] == 2'b00) begin
        keep   = 1'b1;
        op.idx = {1'b0, addr[13:0]};
      end else if (addr[15:14] == 2'b10) begin
        keep   = 1'b1;
        op.idx = {1'b1, addr[13:0]};
      end
    end else if (in_i.bank == BankPlain) begin
      keep = 1'b1;
      if (addr[15:14] == 2'b00 || addr[15:14] == 2'b10) begin
        op.mapped = 1'b1;
        op.idx    = {1'b0, addr[13:0]};
      end
    end else begin
      keep = 1'b1;
      priority if (addr[15:14] == 2'b00 && addr[13:12] != 2'b11) begin
        op.mapped = 1'b1;
        if (patch_hit) begin
          op.decrypt = 1'b1;
          op.idx     = {4'b1000, perm_u5(patch_off)};
        end else begin
          op.idx = {1'b0, addr[13:0]};
        end
      end else if (addr[15:12] == 4'h3) begin
        op.mapped  = 1'b1;
        op.decrypt = 1'b1;
        op.idx     = {3'b111, perm_u7(addr[11:0])};
      end else if (addr[15:11] == 5'b10000) begin
        op.mapped  = 1'b1;
        op.decrypt = 1'b1;
        op.idx     = {4'b1000, perm_u5(addr[10:0])};
      end else if (addr[15:11] == 5'b10001) begin
        op.mapped  = 1'b1;
        op.decrypt = 1'b1;
        op.idx     = {4'b1011, perm_u6(addr[10:0])};
      end else if (addr[15:11] == 5'b10010) begin
        op.mapped  = 1'b1;
        op.decrypt = 1'b1;
        op.idx     = {4'b1010, perm_u6(addr[10:0])};
      end else if (addr[15:11] == 5'b10011 || addr[15:13] == 3'b101) begin
        // mirror of the base image
        op.mapped = 1'b1;
        op.idx    = {1'b0, addr[13:0]};
      end else begin
        op.mapped = 1'b0;
      end
    end
  end

  assign in_i.ready = !q_full_i;
  assign q_push_o   = in_i.valid && !q_full_i && keep;
  assign q_op_o     = op;

endmodule

### rtl/ardo_queue.sv
// ----------------------------------------------------------------------------
// ardo_queue
// Two-entry queue of decoded operations between front and back.
// ----------------------------------------------------------------------------
`include "aux_rom_decrypt_overlay_assert.svh"

module ardo_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  ardo_pkg::op_t push_op_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output ardo_pkg::op_t pop_op_o
);
  import ardo_pkg::*;

  op_t              entry_q [QueueDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] cnt_q, cnt_d;

  assign full_o   = (cnt_q == QCntW'(QueueDepth));
  assign valid_o  = (cnt_q != '0);
  assign pop_op_o = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q + QCntW'(push_i) - QCntW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) entry_q[wr_ptr_q] <= push_op_i;
  end

  `ARDO_ASSERT(a_cnt_bound, clk_i, rst_ni, cnt_q <= QCntW'(QueueDepth), "queue overfilled")
  `ARDO_ASSERT_NEVER(a_push_full, clk_i, rst_ni, push_i && full_o, "push into full queue")
  `ARDO_ASSERT_NEVER(a_pop_empty, clk_i, rst_ni, pop_i && !valid_o, "pop from empty queue")

endmodule

### rtl/ardo_back.sv
// ----------------------------------------------------------------------------
// ardo_back
// Raw image store: performs loads and reads, holds the result for the sink.
// ----------------------------------------------------------------------------
`include "aux_rom_decrypt_overlay_assert.svh"

module ardo_back #(
  parameter int unsigned RawDepth = ardo_pkg::RawDepthDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_valid_i,
  input  ardo_pkg::op_t q_op_i,
  output logic          q_pop_o,
  ardo_out_if.source    out_o
);
  import ardo_pkg::*;

  localparam int unsigned AddrW = $clog2(RawDepth);

  logic [7:0]       mem [RawDepth];
  logic [AddrW-1:0] mem_addr;
  logic             valid_q, valid_d;
  logic             mapped_q;
  logic             decrypt_q;
  logic [7:0]       data_q;
  logic             advance;

  assign advance  = !valid_q || out_o.ready;
  assign q_pop_o  = q_valid_i && advance;
  assign mem_addr = AddrW'(q_op_i.idx);

  always_comb begin
    valid_d = valid_q;
    if (advance) valid_d = q_pop_o && !q_op_i.is_load;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      if (q_op_i.is_load) begin
        mem[mem_addr] <= q_op_i.wdata;
      end else begin
        data_q    <= mem[mem_addr];
        mapped_q  <= q_op_i.mapped;
        decrypt_q <= q_op_i.decrypt;
      end
    end
  end

  assign out_o.valid     = valid_q;
  assign out_o.mapped    = mapped_q;
  assign out_o.read_byte = !mapped_q ? 8'h00 : (decrypt_q ? perm_data(data_q) : data_q);

  `ARDO_ASSERT(a_load_silent, clk_i, rst_ni,
               (q_pop_o && q_op_i.is_load) |=> !valid_q, "load produced a result")
  `ARDO_ASSERT(a_read_shows, clk_i, rst_ni,
               (q_pop_o && !q_op_i.is_load) |=> valid_q, "read result missing")
  `ARDO_ASSERT(a_hold_data, clk_i, rst_ni,
               (valid_q && !out_o.ready) |=> $stable(data_q), "held result changed")

endmodule
